// ===== rtl/core/scft_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scft_pkg;

   typedef logic [1:0] chan_type;

   localparam chan_type CHAN_RED   = 2'd0;
   localparam chan_type CHAN_GREEN = 2'd1;
   localparam chan_type CHAN_BLUE  = 2'd2;

   typedef struct packed {
      logic [31:0] last_tick;
      logic        linear;
      logic [31:0] fade_end;
      logic [31:0] fade_start;
      logic [23:0] shown;
      logic [23:0] goal;
      logic [23:0] start;
   } rec_type;

   typedef struct packed {
      logic [7:0]  mag;
      logic [31:0] elapsed;
      logic [31:0] span;
   } div_req_type;

   function automatic logic [7:0] chan_get(input logic [23:0] colour, input chan_type sel);
      logic [7:0] v;
      case (sel)
         CHAN_RED:   v = colour[23:16];
         CHAN_GREEN: v = colour[15:8];
         default:    v = colour[7:0];
      endcase
      return v;
   endfunction

   function automatic logic [23:0] chan_put(input logic [23:0] colour, input chan_type sel,
                                            input logic [7:0] v);
      logic [23:0] c;
      c = colour;
      case (sel)
         CHAN_RED:   c[23:16] = v;
         CHAN_GREEN: c[15:8]  = v;
         default:    c[7:0]   = v;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/scft_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    we,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                        wdata,
   output      logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/scft_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module scft_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire scft_pkg::div_req_type req,
   output      logic                  done,
   output      logic [7:0]            quot
);
   import scft_pkg::*;

   localparam logic [3:0] CNT_MUL = 4'd9;

   div_req_type op_ff;
   logic [3:0]  cnt_ff;
   logic        done_ff;
   logic [39:0] rem_ff;
   logic [39:0] dsr_ff;
   logic [7:0]  quot_ff;
   logic        ge;

   assign ge = (rem_ff >= dsr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_MUL;
         end else if (cnt_ff != 4'd0) begin
            cnt_ff <= cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         op_ff   <= req;
         quot_ff <= '0;
      end else if (cnt_ff == CNT_MUL) begin
         rem_ff <= {8'd0, op_ff.elapsed} * {32'd0, op_ff.mag};
         dsr_ff <= {1'b0, op_ff.span, 7'd0};
      end else if (cnt_ff != 4'd0) begin
         if (ge) begin
            rem_ff <= rem_ff - dsr_ff;
         end
         quot_ff <= {quot_ff[6:0], ge};
         dsr_ff  <= {1'b0, dsr_ff[39:1]};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== rtl/core/segment_color_fade_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake          payload
// req       in         req_valid/stall    type, segment, tick_time, end_time, rgb, linear_mode
// rsp       out        rsp_valid/stall    seg_id, shown_red, shown_green, shown_blue
//
// One item at a time, whether a load, a plain tick, a linear tick (three multiply and
// divide passes, 8 quotient bits each, in scft_div) or a segment outside the table.
// A stalled result holds off the next item while the output register is full.
// All records live in one single-port RAM; per-entry valid bits read unwritten
// entries as zero, so reset is immediate. Sync active-high reset.
// A result waits in the output register; the next item is taken meanwhile.

module segment_color_fade_table #(
   parameter int NUM_SEGMENTS = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_type,
   input  wire logic [6:0]  req_segment,
   input  wire logic [31:0] req_tick_time,
   input  wire logic [31:0] req_end_time,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   input  wire logic        req_linear_mode,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [6:0]  rsp_seg_id,
   output      logic [7:0]  rsp_shown_red,
   output      logic [7:0]  rsp_shown_green,
   output      logic [7:0]  rsp_shown_blue
);
   import scft_pkg::*;

   localparam int AW = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int RW = $bits(rec_type);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_LOOK   = 7'b0000010,
      ST_PREP   = 7'b0000100,
      ST_DIVIDE = 7'b0001000,
      ST_WRITE  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   state_type         state_ff;
   logic              accept;
   logic [10:0]       seg_wide;
   logic [AW-1:0]     ram_addr;
   logic [RW-1:0]     ram_rdata;
   logic              ram_we;
   logic [NUM_SEGMENTS-1:0] valid_ff;

   logic              type_ff;
   logic [6:0]        seg_ff;
   logic [AW-1:0]     idx_ff;
   logic              range_ff;
   logic [31:0]       tick_ff;
   logic [31:0]       end_ff;
   logic [23:0]       goal_ff;
   logic              lin_ff;
   rec_type           rec_ff;
   rec_type           rec_now;
   rec_type           rec_in;
   chan_type          chan_ff;
   chan_type          chan_sel;
   logic              need_div;

   div_req_type       div_req;
   logic              div_start;
   logic              div_done;
   logic [7:0]        div_quot;
   logic [7:0]        s_sel;
   logic [7:0]        g_sel;
   logic [7:0]        s_cur;
   logic [7:0]        g_cur;
   logic [7:0]        chan_val;

   logic              rsp_valid_ff;
   logic [6:0]        rsp_seg_ff;
   logic [23:0]       rsp_col_ff;
   logic              rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign seg_wide  = {4'd0, req_segment};
   assign ram_addr  = accept ? seg_wide[AW-1:0] : idx_ff;
   assign ram_we    = (state_ff == ST_WRITE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   scft_ram #(
      .WIDTH(RW),
      .DEPTH(NUM_SEGMENTS)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(rec_ff),
      .rdata(ram_rdata)
   );

   assign rec_now = valid_ff[idx_ff] ? rec_type'(ram_rdata) : '0;

   always_comb begin
      rec_in   = rec_now;
      need_div = 1'b0;
      if (!type_ff) begin
         rec_in.start      = rec_now.shown;
         rec_in.goal       = goal_ff;
         rec_in.fade_start = rec_now.last_tick;
         rec_in.fade_end   = end_ff;
         rec_in.linear     = lin_ff;
      end else begin
         rec_in.last_tick = tick_ff;
         if (tick_ff <= rec_now.fade_start) begin
            rec_in.shown = rec_now.start;
         end else if (tick_ff >= rec_now.fade_end || !rec_now.linear) begin
            rec_in.shown = rec_now.goal;
         end else begin
            need_div = 1'b1;
         end
      end
   end

   assign chan_sel  = (state_ff == ST_DIVIDE) ? chan_type'(chan_ff + 2'd1) : CHAN_RED;
   assign s_sel     = chan_get(rec_ff.start, chan_sel);
   assign g_sel     = chan_get(rec_ff.goal, chan_sel);
   assign div_req.mag     = (g_sel >= s_sel) ? (g_sel - s_sel) : (s_sel - g_sel);
   assign div_req.elapsed = rec_ff.last_tick - rec_ff.fade_start;
   assign div_req.span    = rec_ff.fade_end - rec_ff.fade_start;
   assign div_start = (state_ff == ST_PREP) ||
                      (state_ff == ST_DIVIDE && div_done && chan_ff != CHAN_BLUE);

   scft_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .req  (div_req),
      .done (div_done),
      .quot (div_quot)
   );

   assign s_cur    = chan_get(rec_ff.start, chan_ff);
   assign g_cur    = chan_get(rec_ff.goal, chan_ff);
   assign chan_val = (g_cur >= s_cur) ? (s_cur + div_quot) : (s_cur - div_quot);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= (seg_wide < 11'(NUM_SEGMENTS)) ? ST_LOOK : ST_FINISH;
               end
            end
            ST_LOOK: begin
               state_ff <= need_div ? ST_PREP : ST_WRITE;
            end
            ST_PREP: begin
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (div_done && chan_ff == CHAN_BLUE) begin
                  state_ff <= ST_WRITE;
               end
            end
            ST_WRITE: begin
               valid_ff[idx_ff] <= 1'b1;
               state_ff         <= ST_FINISH;
            end
            ST_FINISH: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_type;
         seg_ff   <= req_segment;
         idx_ff   <= seg_wide[AW-1:0];
         range_ff <= (seg_wide < 11'(NUM_SEGMENTS));
         tick_ff  <= req_tick_time;
         end_ff   <= req_end_time;
         goal_ff  <= {req_red, req_green, req_blue};
         lin_ff   <= req_linear_mode;
      end
      if (state_ff == ST_LOOK) begin
         rec_ff <= rec_in;
      end
      if (state_ff == ST_PREP) begin
         chan_ff <= CHAN_RED;
      end
      if (state_ff == ST_DIVIDE && div_done) begin
         rec_ff.shown <= chan_put(rec_ff.shown, chan_ff, chan_val);
         chan_ff      <= chan_type'(chan_ff + 2'd1);
      end
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_seg_ff <= seg_ff;
         rsp_col_ff <= range_ff ? rec_ff.shown : 24'd0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seg_id      = rsp_seg_ff;
   assign rsp_shown_red   = rsp_col_ff[23:16];
   assign rsp_shown_green = rsp_col_ff[15:8];
   assign rsp_shown_blue  = rsp_col_ff[7:0];

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int NSEG = 128;
   localparam int IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        kind;
      logic [6:0]  seg;
      logic [31:0] tick_time;
      logic [31:0] end_time;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        linear;
   } fade_item_t;

   typedef struct packed {
      logic [6:0] seg;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } shown_t;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic req_type = 0;
   logic [6:0] req_segment = 0;
   logic [31:0] req_tick_time = 0;
   logic [31:0] req_end_time = 0;
   logic [7:0] req_red = 0;
   logic [7:0] req_green = 0;
   logic [7:0] req_blue = 0;
   logic req_linear_mode = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [6:0] rsp_seg_id;
   logic [7:0] rsp_shown_red;
   logic [7:0] rsp_shown_green;
   logic [7:0] rsp_shown_blue;

   segment_color_fade_table #(.NUM_SEGMENTS(NSEG)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_segment(req_segment), .req_tick_time(req_tick_time),
      .req_end_time(req_end_time), .req_red(req_red), .req_green(req_green),
      .req_blue(req_blue), .req_linear_mode(req_linear_mode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_seg_id(rsp_seg_id),
      .rsp_shown_red(rsp_shown_red), .rsp_shown_green(rsp_shown_green),
      .rsp_shown_blue(rsp_shown_blue)
   );

   // segment records of the predictor
   logic [23:0] start_col [NSEG];
   logic [23:0] goal_col [NSEG];
   logic [23:0] shown_col [NSEG];
   logic [31:0] fade_t0 [NSEG];
   logic [31:0] fade_t1 [NSEG];
   logic        fade_lin [NSEG];
   logic [31:0] last_t [NSEG];

   fade_item_t pending_items[$];
   shown_t     expected_colors[$];
   int errors = 0;
   int n_loads = 0, n_ticks = 0, n_lerps = 0, n_results = 0;
   int idle_cycles = 0;
   int send_wait = 0, recv_wait = 0;
   bit hold_sender = 0;
   bit stim_done = 0;

   function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] g,
                                                input logic [31:0] el,
                                                input logic [31:0] span);
      logic [63:0] q;
      if (span == 0) return g;
      if (g >= s) begin
         q = (64'(g - s) * 64'(el)) / 64'(span);
         return s + q[7:0];
      end
      q = (64'(s - g) * 64'(el)) / 64'(span);
      return s - q[7:0];
   endfunction

   task automatic show_at(input int i, input logic [31:0] t);
      last_t[i] = t;
      if (t <= fade_t0[i]) begin
         shown_col[i] = start_col[i];
      end else if (t >= fade_t1[i] || !fade_lin[i]) begin
         shown_col[i] = goal_col[i];
      end else begin
         n_lerps++;
         for (int c = 0; c < 3; c++)
            shown_col[i][c*8 +: 8] = blend_channel(start_col[i][c*8 +: 8],
               goal_col[i][c*8 +: 8], t - fade_t0[i], fade_t1[i] - fade_t0[i]);
      end
   endtask

   task automatic predict_colour(input fade_item_t it);
      shown_t r;
      int i;
      i = it.seg;
      r = '0;
      r.seg = it.seg;
      if (i < NSEG) begin
         if (it.kind == 0) begin
            n_loads++;
            start_col[i] = shown_col[i];
            goal_col[i] = {it.blue, it.green, it.red};
            fade_t0[i] = last_t[i];
            fade_t1[i] = it.end_time;
            fade_lin[i] = it.linear;
            show_at(i, last_t[i]);
         end else begin
            n_ticks++;
            show_at(i, it.tick_time);
         end
         r.red = shown_col[i][7:0];
         r.green = shown_col[i][15:8];
         r.blue = shown_col[i][23:16];
      end
      expected_colors.push_back(r);
   endtask

   function automatic fade_item_t make_item(input logic kind, input logic [6:0] seg,
                                            input logic [31:0] t, input logic [31:0] e,
                                            input logic [23:0] rgb, input logic lin);
      fade_item_t it;
      it.kind = kind; it.seg = seg; it.tick_time = t; it.end_time = e;
      it.red = rgb[23:16]; it.green = rgb[15:8]; it.blue = rgb[7:0]; it.linear = lin;
      return it;
   endfunction

   function automatic logic [31:0] rand32();
      return $urandom();
   endfunction

   initial begin
      for (int i = 0; i < NSEG; i++) begin
         start_col[i] = 0; goal_col[i] = 0; shown_col[i] = 0;
         fade_t0[i] = 0; fade_t1[i] = 0; fade_lin[i] = 0; last_t[i] = 0;
      end
   end

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      logic [6:0] s;
      logic [31:0] base, span;
      int steps;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: extremes, both modes, ends of the fade, zero-length fades
      pending_items.push_back(make_item(1, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(0, 0, 32'hFFFFFFFF, 100, 24'hFFFFFF, 1));
      pending_items.push_back(make_item(1, 0, 50, 0, 0, 0));
      pending_items.push_back(make_item(1, 0, 99, 0, 0, 0));
      pending_items.push_back(make_item(1, 0, 100, 0, 0, 0));
      pending_items.push_back(make_item(0, 0, 0, 200, 24'h000000, 1));
      pending_items.push_back(make_item(1, 0, 150, 0, 0, 0));
      pending_items.push_back(make_item(1, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(0, 127, 0, 32'hFFFFFFFF, 24'hFF00FF, 1));
      pending_items.push_back(make_item(1, 127, 32'h7FFFFFFF, 0, 0, 0));
      pending_items.push_back(make_item(1, 127, 32'hFFFFFFFE, 0, 0, 0));
      pending_items.push_back(make_item(1, 127, 32'hFFFFFFFF, 0, 0, 0));
      pending_items.push_back(make_item(0, 5, 0, 1000, 24'h80FF01, 0));
      pending_items.push_back(make_item(1, 5, 1, 32'hFFFFFFFF, 24'hFFFFFF, 1));
      pending_items.push_back(make_item(0, 6, 0, 0, 24'h123456, 1));
      pending_items.push_back(make_item(1, 6, 0, 0, 0, 0));
      pending_items.push_back(make_item(1, 6, 1, 0, 0, 0));
      pending_items.push_back(make_item(1, 7, 500, 0, 0, 0));
      pending_items.push_back(make_item(0, 7, 0, 400, 24'hAA55AA, 1));
      pending_items.push_back(make_item(1, 7, 450, 0, 0, 0));
      pending_items.push_back(make_item(1, 7, 300, 0, 0, 0));
      wait (pending_items.size() == 0 && !req_valid && expected_colors.size() == 0);
      // every result is back; hold the sender before the random phase
      hold_sender = 1;
      repeat (40) @(posedge clock);
      hold_sender = 0;
      // random: mostly fade sequences on a few segments, some noise
      while (n_loads + n_ticks < 1300) begin
         if ($urandom_range(0, 3) == 0) begin
            pending_items.push_back(make_item(1'($urandom_range(0, 1)),
               7'($urandom_range(0, 127)), rand32(), rand32(), 24'(rand32()),
               1'($urandom_range(0, 1))));
            n_ticks += 0;
         end else begin
            s = 7'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 127));
            base = $urandom_range(0, 3) == 0 ? rand32() : $urandom_range(0, 1000);
            span = $urandom_range(0, 3) == 0 ? rand32() : $urandom_range(1, 300);
            pending_items.push_back(make_item(1, s, base, rand32(), 24'(rand32()),
                                              1'(rand32())));
            pending_items.push_back(make_item(0, s, rand32(), base + span, 24'(rand32()),
                                              $urandom_range(0, 4) != 0));
            steps = $urandom_range(1, 6);
            for (int k = 0; k < steps; k++)
               pending_items.push_back(make_item(1, s,
                  base + $urandom_range(0, 2) * (span / 2) +
                  32'(64'(rand32()) % (64'(span) + 64'd2)),
                  rand32(), 24'(rand32()), 1'(rand32())));
         end
         wait (pending_items.size() < 4);
         n_loads = n_loads;
         if (n_results + pending_items.size() >= 1300) break;
      end
      wait (pending_items.size() == 0 && !req_valid);
      stim_done = 1;
   end

   // driver
   always @(posedge clock) begin
      fade_item_t it;
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) predict_colour({req_type, req_segment, req_tick_time, req_end_time,
                                        req_red, req_green, req_blue, req_linear_mode});
         if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req_valid <= 0;
         end else if (pending_items.size() > 0 && !hold_sender) begin
            it = pending_items.pop_front();
            req_valid <= 1;
            req_type <= it.kind; req_segment <= it.seg;
            req_tick_time <= it.tick_time; req_end_time <= it.end_time;
            req_red <= it.red; req_green <= it.green; req_blue <= it.blue;
            req_linear_mode <= it.linear;
            send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      shown_t r;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (expected_colors.size() == 0) begin
               $error("result with nothing expected: seg_id %0d", rsp_seg_id);
               errors++;
            end else begin
               r = expected_colors.pop_front();
               if (rsp_seg_id !== r.seg) begin
                  $error("seg_id expected %0d actual %0d", r.seg, rsp_seg_id); errors++;
               end
               if (rsp_shown_red !== r.red) begin
                  $error("shown_red expected %0d actual %0d", r.red, rsp_shown_red);
                  errors++;
               end
               if (rsp_shown_green !== r.green) begin
                  $error("shown_green expected %0d actual %0d", r.green, rsp_shown_green);
                  errors++;
               end
               if (rsp_shown_blue !== r.blue) begin
                  $error("shown_blue expected %0d actual %0d", r.blue, rsp_shown_blue);
                  errors++;
               end
            end
            recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7);
            rsp_stall <= 1;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // watchdog and end of run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no progress, %0d results outstanding", expected_colors.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      wait (expected_colors.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d loads and %0d ticks, %0d linear blends, %0d results",
               n_loads, n_ticks, n_lerps, n_results);
      if (errors == 0 && expected_colors.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
